[hw/rtl/perlin_noise_3d_defines.svh]
// Assertion macros for the gradient noise RTL.
// No dependencies; included by the top level, perlin_noise_3d, which carries assertions.
`ifndef PERLIN_NOISE_3D_DEFINES_SVH
`define PERLIN_NOISE_3D_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PN3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PN3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pn3_pkg.sv]
// Shared types and constants for the 3D gradient noise block.
// No dependencies.
`default_nettype none
package pn3_pkg;

  localparam int TBL_AW  = 8;            // table index width
  localparam int TBL_N   = 1 << TBL_AW;
  localparam int FRAC    = 16;           // fraction bits of the sample point
  localparam int FADE_W  = 22;           // fade accumulator width
  localparam int DOT_W   = 20;           // corner dot / lerp value width
  localparam int NOISE_W = 16;

  localparam logic [1:0] FN_PERM = 2'd0;
  localparam logic [1:0] FN_GRAD = 2'd1;
  localparam logic [1:0] FN_EVAL = 2'd2;

  localparam logic [3:0] LAST_ISSUE = 4'd13;  // 2 + 4 + 8 hash reads

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_HASH,
    ST_BLEND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } grad_t;

  typedef struct packed {
    logic [TBL_AW-1:0] c0;
    logic [TBL_AW-1:0] c1;
    logic [FRAC-1:0]   fr;
    logic [FRAC:0]     w;
  } axis_res_t;

  typedef struct packed {
    logic              perm_we;
    logic              grad_we;
    logic [TBL_AW-1:0] addr;
    logic [TBL_AW-1:0] perm_data;
    grad_t             grad;
  } tbl_wr_t;

endpackage
`default_nettype wire

[hw/rtl/perlin_noise_3d.sv]
// Top level of the 3D gradient noise block: control, hash sequencing, output register.
// Depends on pn3_pkg, pn3_tables, pn3_axis, pn3_blend and perlin_noise_3d_defines.svh.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | in_tdata (160b), in_tuser = func
//  out_    | out | out_tvalid/tready  | out_tdata = noise, out_tuser = kind
//  cfg_    | in  | cfg_wen            | cfg_wdata = period
//
// Table writes and the unused code go from idle straight to the done state and
// present their result from there; the next item is taken once idle again.
// An evaluation runs the bit-serial coordinate remainder in prep, then 14 serial
// permutation reads on the single read port, then the corner dot pipeline and
// seven blend steps on one multiplier.
// rst_n is synchronous, active low; table contents are not cleared.
// in_tready is high only while idle; a stalled result holds in the output
// register while the next item is already being worked on.
`default_nettype none
`include "perlin_noise_3d_defines.svh"
module perlin_noise_3d import pn3_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // table_index[7:0], perm_value[15:8], grad_x[31:16], grad_y[47:32],
  // grad_z[63:48], pos_x[95:64], pos_y[127:96], pos_z[159:128]
  input  wire logic [159:0] in_tdata,
  // func[1:0]
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // noise[15:0]
  output logic [15:0]       out_tdata,
  // kind[1:0]
  output logic [1:0]        out_tuser,
  input  wire logic         cfg_wen,
  input  wire logic [15:0]  cfg_wdata
);

  state_t state_r, state_nxt;

  logic [15:0]  period_r;
  logic         in_fire, out_load;
  logic [1:0]   kind_r;
  logic signed [NOISE_W-1:0] res_noise_r;
  logic         out_valid_r;
  logic [15:0]  out_noise_r;
  logic [1:0]   out_kind_r;

  tbl_wr_t      tbl_wr;
  logic         perm_rd_en, grad_rd_en;
  logic [TBL_AW-1:0] perm_rd_addr, perm_rd_data;
  grad_t        grad_rd_data;

  logic         axis_start;
  logic [2:0]   axis_done;
  axis_res_t    ax, ay, az;

  logic [3:0]        issue_r, tag_r;
  logic              tag_vld_r;
  logic [TBL_AW-1:0] h1_r [0:1];
  logic [TBL_AW-1:0] h2_r [0:3];
  logic [1:0]        j2;
  logic [2:0]        j3;
  logic              g_vld_r;
  logic [2:0]        g_corner_r;

  logic         blend_done;
  logic signed [NOISE_W-1:0] blend_noise;

  assign in_fire    = in_tvalid && in_tready;
  assign out_load   = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign axis_start = in_fire && (in_tuser == FN_EVAL);

  always_ff @(posedge clk) begin
    if (!rst_n)       period_r <= '0;
    else if (cfg_wen) period_r <= cfg_wdata;
  end

  // table loads go straight to the memories at accept
  always_comb begin
    tbl_wr.perm_we   = in_fire && (in_tuser == FN_PERM);
    tbl_wr.grad_we   = in_fire && (in_tuser == FN_GRAD);
    tbl_wr.addr      = in_tdata[7:0];
    tbl_wr.perm_data = in_tdata[15:8];
    tbl_wr.grad.x    = in_tdata[31:16];
    tbl_wr.grad.y    = in_tdata[47:32];
    tbl_wr.grad.z    = in_tdata[63:48];
  end

  pn3_axis u_axis_x (.clk, .rst_n, .start(axis_start), .pos(in_tdata[95:64]),
                     .period(period_r), .done(axis_done[0]), .res(ax));
  pn3_axis u_axis_y (.clk, .rst_n, .start(axis_start), .pos(in_tdata[127:96]),
                     .period(period_r), .done(axis_done[1]), .res(ay));
  pn3_axis u_axis_z (.clk, .rst_n, .start(axis_start), .pos(in_tdata[159:128]),
                     .period(period_r), .done(axis_done[2]), .res(az));

  pn3_tables u_tables (
    .clk,
    .wr           (tbl_wr),
    .perm_rd_en   (perm_rd_en),
    .perm_rd_addr (perm_rd_addr),
    .perm_rd_data (perm_rd_data),
    .grad_rd_en   (grad_rd_en),
    .grad_rd_addr (perm_rd_data),
    .grad_rd_data (grad_rd_data)
  );

  // state machine
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    perm_rd_en = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = (in_tuser == FN_EVAL) ? ST_PREP : ST_DONE;
      end
      ST_PREP:  if (axis_done[0]) state_nxt = ST_HASH;
      ST_HASH: begin
        perm_rd_en = 1'b1;
        if (issue_r == LAST_ISSUE) state_nxt = ST_BLEND;
      end
      ST_BLEND: if (blend_done) state_nxt = ST_DONE;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Hash read order: two x-level reads, four y-level, eight z-level.
  // Each level's sum uses a hash already captured into h1_r or h2_r.
  assign j2 = 2'(issue_r - 4'd2);
  assign j3 = 3'(issue_r - 4'd6);

  always_comb begin
    if (issue_r < 4'd2)      perm_rd_addr = issue_r[0] ? ax.c1 : ax.c0;
    else if (issue_r < 4'd6) perm_rd_addr = h1_r[j2[0]] + (j2[1] ? ay.c1 : ay.c0);
    else                     perm_rd_addr = h2_r[j3[1:0]] + (j3[2] ? az.c1 : az.c0);
  end

  assign grad_rd_en = tag_vld_r && (tag_r >= 4'd6);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r   <= '0;
      tag_vld_r <= 1'b0;
      g_vld_r   <= 1'b0;
    end else begin
      tag_vld_r <= perm_rd_en;
      g_vld_r   <= grad_rd_en;
      if (state_r == ST_HASH) issue_r <= issue_r + 4'd1;
      else                    issue_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    tag_r      <= issue_r;
    g_corner_r <= 3'(tag_r - 4'd6);
    if (tag_vld_r) begin
      if (tag_r < 4'd2)      h1_r[tag_r[0]] <= perm_rd_data;
      else if (tag_r < 4'd6) h2_r[2'(tag_r - 4'd2)] <= perm_rd_data;
    end
  end

  pn3_blend u_blend (
    .clk, .rst_n,
    .g_vld    (g_vld_r),
    .g_corner (g_corner_r),
    .g        (grad_rd_data),
    .ax, .ay, .az,
    .done     (blend_done),
    .noise    (blend_noise)
  );

  // pending result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r      <= in_tuser;
      res_noise_r <= '0;
    end else if (blend_done) begin
      res_noise_r <= blend_noise;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_noise_r <= res_noise_r;
      out_kind_r  <= kind_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_noise_r;
  assign out_tuser  = out_kind_r;

  `PN3_ASSERT_NOW(a_axis_sync, axis_done[0], axis_done[1] && axis_done[2], "axis units out of step")
  `PN3_ASSERT_NOW(a_blend_phase, blend_done, state_r == ST_BLEND, "blend done outside blend phase")
  `PN3_ASSERT_NOW(a_grad_rd, grad_rd_en, state_r == ST_HASH || state_r == ST_BLEND, "stray gradient read")
  `PN3_ASSERT_NEXT(a_out_load, out_load, out_tvalid, "loaded result not presented")

endmodule
`default_nettype wire

[hw/rtl/pn3_tables.sv]
// Permutation and gradient memories, one write and one read port each.
// Depends on pn3_pkg.
`default_nettype none
module pn3_tables import pn3_pkg::*; (
  input  wire logic              clk,
  input  wire tbl_wr_t           wr,
  input  wire logic              perm_rd_en,
  input  wire logic [TBL_AW-1:0] perm_rd_addr,
  output logic [TBL_AW-1:0]      perm_rd_data,
  input  wire logic              grad_rd_en,
  input  wire logic [TBL_AW-1:0] grad_rd_addr,
  output grad_t                  grad_rd_data
);

  logic [TBL_AW-1:0] perm_mem [0:TBL_N-1];
  grad_t             grad_mem [0:TBL_N-1];

  always_ff @(posedge clk) begin
    if (wr.perm_we) perm_mem[wr.addr] <= wr.perm_data;
    if (perm_rd_en) perm_rd_data <= perm_mem[perm_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.grad_we) grad_mem[wr.addr] <= wr.grad;
    if (grad_rd_en) grad_rd_data <= grad_mem[grad_rd_addr];
  end

endmodule
`default_nettype wire

[hw/rtl/pn3_axis.sv]
// One axis: lattice cell wrap (bit-serial remainder) and quintic fade.
// Depends on pn3_pkg.
`default_nettype none
module pn3_axis import pn3_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] pos,
  input  wire logic [15:0] period,
  output logic             done,
  output axis_res_t        res
);

  localparam logic signed [FADE_W-1:0] FADE_15 = FADE_W'(15 << FRAC);
  localparam logic signed [FADE_W-1:0] FADE_10 = FADE_W'(10 << FRAC);
  localparam logic signed [FADE_W-1:0] FADE_1  = FADE_W'(1 << FRAC);

  logic                     busy_r, done_r;
  logic [3:0]               cnt_r;
  logic signed [15:0]       ip_r;
  logic [FRAC-1:0]          fr_r;
  logic [15:0]              mag_r, rem_r;
  logic signed [FADE_W-1:0] a_r;

  logic [16:0]                   rem_sh;
  logic [15:0]                   rem_nxt;
  logic signed [FADE_W-1:0]      a_init, a_nxt;
  logic signed [FADE_W+FRAC:0]   prod;
  logic [16:0]                   r0, r1, rem_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring remainder, one dividend bit per cycle
  assign rem_sh  = {rem_r, mag_r[15]};
  assign rem_nxt = (rem_sh >= {1'b0, period}) ? 16'(rem_sh - {1'b0, period})
                                              : rem_sh[15:0];

  // fade: a = 6t - 15, then a = a*t + 10, then three plain a = a*t steps
  assign a_init = $signed(FADE_W'({pos[FRAC-1:0], 2'b00}) + FADE_W'({pos[FRAC-1:0], 1'b0}))
                  - FADE_15;
  assign prod   = a_r * $signed({1'b0, fr_r});
  assign a_nxt  = $signed(prod[FRAC+FADE_W-1:FRAC]) + ((cnt_r == 4'd0) ? FADE_10 : '0);

  always_ff @(posedge clk) begin
    if (start) begin
      ip_r  <= pos[31:16];
      fr_r  <= pos[FRAC-1:0];
      mag_r <= pos[31] ? 16'(~pos[31:16] + 16'd1) : pos[31:16];
      rem_r <= '0;
      a_r   <= a_init;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      mag_r <= {mag_r[14:0], 1'b0};
      if (cnt_r < 4'd4) a_r <= a_nxt;
    end
  end

  // truncating remainder: sign follows the coordinate
  assign rem_inc = {1'b0, rem_r} + 17'd1;
  assign r0 = ip_r[15] ? 17'(~{1'b0, rem_r} + 17'd1) : {1'b0, rem_r};
  always_comb begin
    if (!ip_r[15]) r1 = (rem_inc == {1'b0, period}) ? 17'd0 : rem_inc;
    else           r1 = (rem_r == 16'd0) ? 17'(17'd1 - {1'b0, period}) : 17'(r0 + 17'd1);
  end

  always_comb begin
    if (period == 16'd0) begin
      res.c0 = ip_r[TBL_AW-1:0];
      res.c1 = ip_r[TBL_AW-1:0] + TBL_AW'(1);
    end else begin
      res.c0 = r0[TBL_AW-1:0];
      res.c1 = r1[TBL_AW-1:0];
    end
    res.fr = fr_r;
    if (a_r < 0)            res.w = '0;
    else if (a_r > FADE_1)  res.w = FADE_1[FRAC:0];
    else                    res.w = a_r[FRAC:0];
  end

  assign done = done_r;

endmodule
`default_nettype wire

[hw/rtl/pn3_blend.sv]
// Corner dot products and the seven-step trilinear blend.
// Depends on pn3_pkg.
`default_nettype none
module pn3_blend import pn3_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        g_vld,
  input  wire logic [2:0]  g_corner,
  input  wire grad_t       g,
  input  wire axis_res_t   ax,
  input  wire axis_res_t   ay,
  input  wire axis_res_t   az,
  output logic             done,
  output logic signed [NOISE_W-1:0] noise
);

  localparam logic signed [FRAC+1:0] ONE_S = (FRAC+2)'(1 << FRAC);
  localparam logic signed [35:0]     DOT_RND = 36'sd16384;
  localparam logic signed [DOT_W+FRAC+2:0] LRP_RND = (DOT_W+FRAC+3)'(1 << (FRAC-1));
  localparam logic signed [DOT_W-1:0] SAT_HI = DOT_W'(32767);
  localparam logic signed [DOT_W-1:0] SAT_LO = -DOT_W'(32768);

  logic signed [FRAC+1:0] dx, dy, dz;
  logic                   s1_vld_r;
  logic [2:0]             s1_corner_r;
  logic signed [33:0]     px_r, py_r, pz_r;
  logic signed [35:0]     dsum;
  logic signed [DOT_W-1:0] dot;
  logic signed [DOT_W-1:0] d_r [0:7];
  logic signed [DOT_W-1:0] l_r [0:5];

  logic                    lp_busy_r, phase_r, done_r;
  logic [2:0]              step_r;
  logic signed [DOT_W-1:0] op_a, op_b, la_r, lres;
  logic [FRAC:0]           op_w;
  logic signed [DOT_W:0]   diff;
  logic signed [DOT_W+FRAC+2:0] lprod_r, lrnd;
  logic signed [NOISE_W-1:0] noise_r;

  assign dx = $signed({2'b00, ax.fr}) - (g_corner[0] ? ONE_S : '0);
  assign dy = $signed({2'b00, ay.fr}) - (g_corner[1] ? ONE_S : '0);
  assign dz = $signed({2'b00, az.fr}) - (g_corner[2] ? ONE_S : '0);

  always_ff @(posedge clk) begin
    px_r        <= $signed(g.x) * dx;
    py_r        <= $signed(g.y) * dy;
    pz_r        <= $signed(g.z) * dz;
    s1_corner_r <= g_corner;
  end

  // round half up into Q.15
  assign dsum = $signed({{2{px_r[33]}}, px_r}) + $signed({{2{py_r[33]}}, py_r})
              + $signed({{2{pz_r[33]}}, pz_r}) + DOT_RND;
  assign dot  = dsum[15+DOT_W-1:15];

  always_ff @(posedge clk) begin
    if (s1_vld_r) d_r[s1_corner_r] <= dot;
  end

  // operand select: x pairs, then y pairs, then z
  always_comb begin
    case (step_r)
      3'd0:    begin op_a = d_r[0]; op_b = d_r[1]; end
      3'd1:    begin op_a = d_r[2]; op_b = d_r[3]; end
      3'd2:    begin op_a = d_r[4]; op_b = d_r[5]; end
      3'd3:    begin op_a = d_r[6]; op_b = d_r[7]; end
      3'd4:    begin op_a = l_r[0]; op_b = l_r[1]; end
      3'd5:    begin op_a = l_r[2]; op_b = l_r[3]; end
      default: begin op_a = l_r[4]; op_b = l_r[5]; end
    endcase
    if (step_r < 3'd4)      op_w = ax.w;
    else if (step_r < 3'd6) op_w = ay.w;
    else                    op_w = az.w;
  end

  assign diff = {op_b[DOT_W-1], op_b} - {op_a[DOT_W-1], op_a};
  assign lrnd = lprod_r + LRP_RND;
  assign lres = la_r + lrnd[FRAC+DOT_W-1:FRAC];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      lp_busy_r <= 1'b0;
      phase_r   <= 1'b0;
      step_r    <= '0;
      done_r    <= 1'b0;
    end else begin
      s1_vld_r <= g_vld;
      done_r   <= 1'b0;
      if (s1_vld_r && s1_corner_r == 3'd7) begin
        lp_busy_r <= 1'b1;
        phase_r   <= 1'b0;
        step_r    <= '0;
      end else if (lp_busy_r) begin
        phase_r <= ~phase_r;
        if (phase_r) begin
          if (step_r == 3'd6) begin
            lp_busy_r <= 1'b0;
            done_r    <= 1'b1;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lp_busy_r && !phase_r) begin
      lprod_r <= diff * $signed({1'b0, op_w});
      la_r    <= op_a;
    end
    if (lp_busy_r && phase_r) begin
      if (step_r != 3'd6) l_r[step_r] <= lres;
      if (lres > SAT_HI)      noise_r <= 16'sh7fff;
      else if (lres < SAT_LO) noise_r <= 16'sh8000;
      else                    noise_r <= lres[NOISE_W-1:0];
    end
  end

  assign done  = done_r;
  assign noise = noise_r;

endmodule
`default_nettype wire
